>>> src/jdc_pkg.sv
// Shared types, constants and the axis scaling function for the joystick conditioner.
`default_nettype none

package jdc_pkg;

    // Sample field widths
    localparam int ADC_BITS  = 10;
    localparam int TIME_BITS = 32;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam int DZ_BITS    = 7;
    localparam int PULSE_BITS = 16;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEAD_ZONE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_LEN = CFG_INDEX_BITS'(1);

    localparam logic [DZ_BITS-1:0]    DEAD_ZONE_RST = DZ_BITS'(10);
    localparam logic [PULSE_BITS-1:0] PULSE_LEN_RST = PULSE_BITS'(50);

    // Full-scale ADC code, one bit wider to hold remainders up to twice its value
    localparam logic [ADC_BITS:0] ADC_MAX = {1'b0, {ADC_BITS{1'b1}}};

    localparam logic signed [8:0] POS_OFFSET = 9'sd100;

    typedef struct packed {
        logic [ADC_BITS-1:0]  x_raw;
        logic [ADC_BITS-1:0]  y_raw;
        logic                 button_level;
        logic [TIME_BITS-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] x_pos;
        logic signed [7:0] y_pos;
        logic              dir_left;
        logic              dir_right;
        logic              dir_up;
        logic              dir_down;
        logic              moving;
        logic              press_pulse;
    } result_t;

    // floor(raw * 200 / ADC_MAX) where ADC_MAX = 2^ADC_BITS - 1.
    // Estimate with a shift, then correct once: the remainder stays below 2*ADC_MAX.
    function automatic logic [7:0] jdc_scale(input logic [ADC_BITS-1:0] raw);
        logic [ADC_BITS+7:0] wide;
        logic [ADC_BITS+7:0] prod;
        logic [7:0]          q_est;
        logic [ADC_BITS:0]   rem;
        wide  = {8'd0, raw};
        prod  = (wide << 7) + (wide << 6) + (wide << 3);
        q_est = prod[ADC_BITS+7:ADC_BITS];
        rem   = {1'b0, prod[ADC_BITS-1:0]} + {{(ADC_BITS-7){1'b0}}, q_est};
        return q_est + {7'd0, (rem >= ADC_MAX)};
    endfunction

endpackage

`default_nettype wire

>>> src/jdc_band.sv
// Deadband zeroing and direction flags for one scaled axis.
`default_nettype none

module jdc_band
    import jdc_pkg::*;
(
    input  wire logic signed [8:0]         pos,
    input  wire logic [DZ_BITS-1:0]        dead_zone,
    output logic signed [7:0]              pos_out,
    output logic                           below,
    output logic                           above
);

    logic signed [8:0] dz_pos;
    logic signed [8:0] dz_neg;
    logic              in_band;

    always_comb
    begin
        dz_pos  = $signed({2'b00, dead_zone});
        dz_neg  = -dz_pos;
        in_band = (pos > dz_neg) && (pos < dz_pos);
        pos_out = in_band ? 8'sd0 : pos[7:0];
        below   = pos < dz_neg;
        above   = pos > dz_pos;
    end

endmodule

`default_nettype wire

>>> src/jdc_button.sv
// Button arm/press state and the timed press pulse.
`default_nettype none

module jdc_button
    import jdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  level,
    input  wire logic [TIME_BITS-1:0]  now_ms,
    input  wire logic [PULSE_BITS-1:0] pulse_length_ms,
    output logic                       press_pulse
);

    logic                 active_reg, active_next;
    logic                 armed_reg, armed_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 active_kept;

    always_comb
    begin
        elapsed     = now_ms - start_reg;
        active_kept = active_reg &&
                      !(elapsed > {{(TIME_BITS-PULSE_BITS){1'b0}}, pulse_length_ms});
        active_next = active_kept;
        armed_next  = armed_reg;
        start_next  = start_reg;
        if (level)
        begin
            armed_next = 1'b1;
        end
        else if (armed_reg)
        begin
            // start a new pulse and disarm until the level goes high again
            active_next = 1'b1;
            armed_next  = 1'b0;
            start_next  = now_ms;
        end
        press_pulse = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            armed_reg  <= 1'b1;
            start_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            armed_reg  <= armed_next;
            start_reg  <= start_next;
        end
    end

endmodule

`default_nettype wire

>>> src/joystick_deadband_conditioner.sv
// Top level of the joystick deadband conditioner: sample and result registers, config.
//
// Usage:
//   sample channel: sample_valid / sample_stall / sample (x_raw, y_raw, button_level,
//   now_ms). A beat moves on a rising edge with valid high and stall low.
//   result channel: result_valid / result_stall / result (positions, direction flags,
//   moving, press_pulse). One result beat for every sample beat, in order.
//   config channel: cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is always
//   high. Index 0 writes dead_zone (low 7 bits), index 1 writes pulse_length_ms
//   (low 16 bits); other indexes are dropped. Write only while the block is idle.
// Timing:
//   The sample register takes the beat, then the result register loads it through the
//   scaling, deadband and button logic. Throughput: one sample per cycle unless stalled;
//   the scaling is a constant multiply with one correcting compare, so nothing iterates.
// Reset:
//   rst_n clears both valid flags, loads dead_zone = 10 and pulse_length_ms = 50,
//   and leaves the button armed with no pulse active.
// Stall:
//   While result_stall holds the result, the sample register still takes one more
//   beat; sample_stall rises only when both registers are full and the output stalls.
`default_nettype none

module joystick_deadband_conditioner
    import jdc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      sample_valid,
    output logic                           sample_stall,
    input  wire sample_t                   sample,

    output logic                           result_valid,
    input  wire logic                      result_stall,
    output result_t                        result,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers
    logic [DZ_BITS-1:0]    dead_zone_reg;
    logic [PULSE_BITS-1:0] pulse_len_reg;

    // Sample stage
    logic    smp_valid_reg, smp_valid_next;
    sample_t smp_reg;

    // Result stage
    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    logic out_load;
    logic advance;
    logic take;

    logic [7:0]        x_scaled, y_scaled;
    logic signed [8:0] x_pos_w, y_pos_w;
    logic signed [7:0] x_band, y_band;
    logic              left, right, up, down;
    logic              pulse;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            pulse_len_reg <= PULSE_LEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[DZ_BITS-1:0];
                CFG_PULSE_LEN: pulse_len_reg <= cfg_data[PULSE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: result register loads when empty or drained this cycle
    always_comb
    begin
        out_load       = !res_valid_reg || !result_stall;
        advance        = smp_valid_reg && out_load;
        sample_stall   = smp_valid_reg && !out_load;
        take           = sample_valid && !sample_stall;
        smp_valid_next = take || (smp_valid_reg && !advance);
        res_valid_next = out_load ? smp_valid_reg : res_valid_reg;
    end

    // Scale each axis to -100..100; y runs the other way
    always_comb
    begin
        x_scaled = jdc_scale(smp_reg.x_raw);
        y_scaled = jdc_scale(smp_reg.y_raw);
        x_pos_w  = $signed({1'b0, x_scaled}) - POS_OFFSET;
        y_pos_w  = POS_OFFSET - $signed({1'b0, y_scaled});
    end

    jdc_band u_band_x (
        .pos       (x_pos_w),
        .dead_zone (dead_zone_reg),
        .pos_out   (x_band),
        .below     (left),
        .above     (right)
    );

    jdc_band u_band_y (
        .pos       (y_pos_w),
        .dead_zone (dead_zone_reg),
        .pos_out   (y_band),
        .below     (up),
        .above     (down)
    );

    // Button state steps once per sample, as the sample leaves for the result register
    jdc_button u_button (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .level           (smp_reg.button_level),
        .now_ms          (smp_reg.now_ms),
        .pulse_length_ms (pulse_len_reg),
        .press_pulse     (pulse)
    );

    always_comb
    begin
        res_next.x_pos       = x_band;
        res_next.y_pos       = y_band;
        res_next.dir_left    = left;
        res_next.dir_right   = right;
        res_next.dir_up      = up;
        res_next.dir_down    = down;
        res_next.moving      = left || right || up || down;
        res_next.press_pulse = pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: hold unless a beat moves in
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            smp_reg <= sample;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

>>> tb/sv/jdc_checker.sv
// Checker for the joystick conditioner: watches the channels, predicts each result and compares.
module jdc_checker
    import jdc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      sample_valid,
    input  wire logic                      sample_stall,
    input  wire sample_t                   sample,
    input  wire logic                      result_valid,
    input  wire logic                      result_stall,
    input  wire result_t                   result,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                             mismatches,
    output int                             in_flight,
    output int                             checked,
    output int                             pulses
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;

    // Own copy of the registers and the button state
    logic [DZ_BITS-1:0]    dz_reg   = DEAD_ZONE_RST;
    logic [PULSE_BITS-1:0] len_reg  = PULSE_LEN_RST;
    logic                  pulse_on = 1'b0;
    logic                  armed    = 1'b1;
    logic [TIME_BITS-1:0]  pulse_t0 = '0;

    result_t due[$];
    result_t want;
    int      errors        = 0;
    int      results_seen  = 0;
    int      pulse_results = 0;
    int      depth         = 0;

    assign mismatches = errors;
    assign in_flight  = depth;
    assign checked    = results_seen;
    assign pulses     = pulse_results;

    // Condition one sample: expire the pulse first, then handle the button edge.
    function automatic result_t condition_sample(input sample_t s);
        result_t              r;
        int                   lim;
        int                   x_pct;
        int                   y_pct;
        logic [TIME_BITS-1:0] elapsed;
        lim     = int'(dz_reg);
        x_pct   = (int'(s.x_raw) * 200) / FULL_SCALE - 100;
        y_pct   = 100 - (int'(s.y_raw) * 200) / FULL_SCALE;
        elapsed = s.now_ms - pulse_t0;
        if (pulse_on && elapsed > TIME_BITS'(len_reg))
            pulse_on = 1'b0;
        if (s.button_level)
            armed = 1'b1;
        else if (armed)
        begin
            pulse_on = 1'b1;
            armed    = 1'b0;
            pulse_t0 = s.now_ms;
        end
        r.x_pos       = (x_pct > -lim && x_pct < lim) ? 8'sd0 : 8'(x_pct);
        r.y_pos       = (y_pct > -lim && y_pct < lim) ? 8'sd0 : 8'(y_pct);
        r.dir_left    = x_pct < -lim;
        r.dir_right   = x_pct > lim;
        r.dir_up      = y_pct < -lim;
        r.dir_down    = y_pct > lim;
        r.moving      = r.dir_left | r.dir_right | r.dir_up | r.dir_down;
        r.press_pulse = pulse_on;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(exp_v), $signed(act_v));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   = DEAD_ZONE_RST;
            len_reg  = PULSE_LEN_RST;
            pulse_on = 1'b0;
            armed    = 1'b1;
            pulse_t0 = '0;
            due.delete();
            depth <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEAD_ZONE: dz_reg = cfg_data[DZ_BITS-1:0];
                    CFG_PULSE_LEN: len_reg = cfg_data[PULSE_BITS-1:0];
                    default: ;
                endcase
            end
            // Retire the result beat before queuing a new sample beat.
            if (result_valid && !result_stall)
            begin
                if (due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with none expected, expected nothing, actual %p",
                             $time, result);
                end
                else
                begin
                    want = due.pop_front();
                    check_field("x_pos", want.x_pos, result.x_pos);
                    check_field("y_pos", want.y_pos, result.y_pos);
                    check_field("dir_left", want.dir_left, result.dir_left);
                    check_field("dir_right", want.dir_right, result.dir_right);
                    check_field("dir_up", want.dir_up, result.dir_up);
                    check_field("dir_down", want.dir_down, result.dir_down);
                    check_field("moving", want.moving, result.moving);
                    check_field("press_pulse", want.press_pulse, result.press_pulse);
                    results_seen++;
                    if (want.press_pulse)
                        pulse_results++;
                end
            end
            if (sample_valid && !sample_stall)
                due.push_back(condition_sample(sample));
            depth <= due.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the joystick conditioner: clock, reset, stimulus, stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    localparam int CYCLE_LIMIT      = 200_000;
    localparam int LONG_HOLD        = 300;
    localparam int RANDOM_PER_PHASE = 312;
    localparam int SETTLE           = 8;
    localparam int FULL_SCALE       = (1 << ADC_BITS) - 1;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample       = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    // Scoreboard status handed up by the checker
    int mismatches;
    int in_flight;
    int checked;
    int pulses;

    // Stimulus state: the millisecond clock we feed in, the button level we hold,
    // and our own view of the registers so the random beats land near edges.
    logic [TIME_BITS-1:0] clock_ms    = '0;
    logic                 btn         = 1'b1;
    int                   dz_now      = int'(DEAD_ZONE_RST);
    int                   len_now     = int'(PULSE_LEN_RST);
    int                   burst_left  = 1;
    bit                   gapless     = 1'b0;
    int                   hold_asked  = 0;
    int                   hold_served = 0;
    int                   beats_sent  = 0;
    int                   settings    = 1;
    int                   cycles      = 0;

    joystick_deadband_conditioner u_top (.*);

    jdc_checker u_chk (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still due", cycles, in_flight);
        $display("Some tests failed");
        $finish;
    end

    // Raw ADC code whose scaled value is exactly q (0..200), clamped to the range.
    function automatic logic [ADC_BITS-1:0] raw_at(input int q);
        int qc;
        qc = (q < 0) ? 0 : (q > 200) ? 200 : q;
        return ADC_BITS'((qc * FULL_SCALE + 199) / 200);
    endfunction

    // Pick one axis reading: mostly around the deadband edges, some full range,
    // some at the rails. The band is symmetric, so x and y share this.
    function automatic logic [ADC_BITS-1:0] pick_axis(input int band);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ADC_BITS'($urandom);
            4:          return $urandom_range(0, 1) ? ADC_BITS'(FULL_SCALE) : '0;
            default:    return raw_at(100 - band - 2 + $urandom_range(0, 2 * band + 4));
        endcase
    endfunction

    // Offer one sample beat and hold it until taken. Between bursts drop valid
    // for a random gap; within a burst valid stays high, so it is never lowered
    // and raised in the same step.
    task automatic send(input logic [ADC_BITS-1:0] x, input logic [ADC_BITS-1:0] y,
                        input logic b, input logic [TIME_BITS-1:0] t);
        sample_valid <= 1'b1;
        sample       <= '{x_raw: x, y_raw: y, button_level: b, now_ms: t};
        do @(posedge clk); while (sample_stall);
        beats_sent++;
        burst_left--;
        if (!gapless && burst_left <= 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // Now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Random beat: well-formed button runs, with the time stepping mostly in
    // small increments or right around the pulse length, and some jumps and wraps.
    task automatic send_random();
        int band;
        band = (dz_now > 100) ? 100 : dz_now;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: clock_ms += $urandom_range(0, 3);
            5, 6, 7:       clock_ms += TIME_BITS'(len_now + $urandom_range(0, 2) - 1);
            8:             clock_ms = $urandom;
            default:       clock_ms = 32'hFFFF_FFFC + $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 3) == 0)
            btn = ~btn;
        send(pick_axis(band), pick_axis(band), btn, clock_ms);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_random();
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain();
        if (sample_valid)
            sample_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    // One config beat; valid is left high so back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Reprogram both registers while the block is idle, plus one write to an
    // index past the register map, which the block must drop.
    task automatic configure(input logic [CFG_DATA_BITS-1:0] dz_word,
                             input logic [CFG_DATA_BITS-1:0] len_word);
        drain();
        write_reg(CFG_DEAD_ZONE, dz_word);
        write_reg(CFG_PULSE_LEN, len_word);
        write_reg(CFG_INDEX_BITS'($urandom_range(int'(CFG_PULSE_LEN) + 1,
                                                 (1 << CFG_INDEX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
        dz_now  = int'(dz_word[DZ_BITS-1:0]);
        len_now = int'(len_word[PULSE_BITS-1:0]);
        settings++;
    endtask

    // Receiver: stall on a pattern that changes every segment. A pending long
    // hold-off request holds stall high, so the block fills.
    initial
    begin
        int mode;
        int seg;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            for (int i = 0; i < seg; i++)
            begin
                @(posedge clk);
                if (hold_served != hold_asked)
                begin
                    result_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_served++;
                end
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= ((i % 5) < 2);
                endcase
            end
        end
    end

    // Main stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: dead zone 10, pulse 50 ms.
        // Rails, then each axis just at and just past the band edges on both sides.
        send('0, '0, 1'b1, 32'd0);
        send(ADC_BITS'(FULL_SCALE), ADC_BITS'(FULL_SCALE), 1'b1, 32'd1);
        send(raw_at(99), raw_at(100), 1'b1, 32'd2);
        send(raw_at(90), raw_at(110), 1'b1, 32'd3);
        send(raw_at(89), raw_at(111), 1'b1, 32'd4);
        send(raw_at(110), raw_at(90), 1'b1, 32'd5);
        send(raw_at(111), raw_at(89), 1'b1, 32'd6);
        send(raw_at(101), raw_at(99), 1'b1, 32'd7);
        // Press, hold at exactly the pulse length, expire one ms later, re-arm
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'd1000);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'd1001);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'd1051);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'd1052);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'd1053);
        // Press again while the pulse is still running: restarts the start time
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'd1060);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'd1061);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'd1062);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'd1112);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'd1113);
        // Pulse that spans the timestamp wrap
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b1, 32'hFFFF_FFF0);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'hFFFF_FFF8);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'h0000_002A);
        send(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0, 32'h0000_002B);
        clock_ms = 32'h0000_002B;
        btn      = 1'b0;
        run_random(RANDOM_PER_PHASE);

        // No dead zone, zero pulse length: any nonzero value flags, and the
        // pulse survives only samples stamped with its own start time.
        configure('0, '0);
        send(raw_at(100), raw_at(100), 1'b1, 32'd5000);
        send(raw_at(101), raw_at(99), 1'b0, 32'd5005);
        send(raw_at(99), raw_at(101), 1'b0, 32'd5005);
        send(raw_at(100), raw_at(100), 1'b0, 32'd5006);
        clock_ms = 32'd5006;
        btn      = 1'b0;
        run_random(RANDOM_PER_PHASE);

        // Widest legal band, longest pulse. Midway, hold the receiver off for a
        // long stretch while beats keep coming back to back, so the input stalls.
        configure(CFG_DATA_BITS'(100), CFG_DATA_BITS'(16'hFFFF));
        run_random(RANDOM_PER_PHASE / 2);
        hold_asked++;
        gapless = 1'b1;
        run_random(20);
        gapless = 1'b0;
        run_random(RANDOM_PER_PHASE / 2 - 20);

        // Dead zone word with high bits set: masks to 127, past every value.
        configure(CFG_DATA_BITS'(16'hFF7F), CFG_DATA_BITS'(1));
        send('0, ADC_BITS'(FULL_SCALE), 1'b1, clock_ms);
        send(ADC_BITS'(FULL_SCALE), '0, 1'b0, clock_ms + 1);
        send(ADC_BITS'(FULL_SCALE), '0, 1'b0, clock_ms + 2);
        send('0, ADC_BITS'(FULL_SCALE), 1'b0, clock_ms + 3);
        clock_ms += 3;
        btn = 1'b0;
        run_random(RANDOM_PER_PHASE);

        // Random band and short pulse. Midway, pause until everything is back.
        configure(CFG_DATA_BITS'($urandom_range(1, 99)), CFG_DATA_BITS'($urandom_range(0, 200)));
        run_random(RANDOM_PER_PHASE / 2);
        drain();
        run_random(RANDOM_PER_PHASE / 2);

        // Fully random register words
        configure(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
        run_random(RANDOM_PER_PHASE);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Run: %0d sample beats under %0d register settings, %0d results checked,",
                 beats_sent, settings, checked);
        $display("     %0d of them with the press pulse set, %0d mismatches.",
                 pulses, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
